[rtl/core/bts_pkg.sv]
package bts_pkg;

  localparam int MAX_TEXELS_DEF    = 16384;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int SIDE_W  = 8;   // width of a size register
  localparam int POS_W   = 7;   // texel column or row, 0..127
  localparam int IDX_W   = 14;  // row-major texel index
  localparam int CH_W    = 8;
  localparam int NUM_CH  = 3;
  localparam int TEXEL_W = CH_W * NUM_CH;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [SIDE_W-1:0] MAX_SIDE = 8'd128;

  // operation codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // register select, taken from paddr[2]
  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  // texel read slots within one sample
  localparam logic [1:0] TAP_TL = 2'd0;
  localparam logic [1:0] TAP_TR = 2'd1;
  localparam logic [1:0] TAP_BL = 2'd2;
  localparam logic [1:0] TAP_BR = 2'd3;

  typedef struct packed {
    logic               op;
    logic [IDX_W-1:0]   texel_address;
    logic [CH_W-1:0]    texel_red;
    logic [CH_W-1:0]    texel_green;
    logic [CH_W-1:0]    texel_blue;
    logic signed [31:0] coord_u;
    logic signed [31:0] coord_v;
  } bts_in_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
  } bts_out_t;

  // tag travelling with a texel read
  typedef struct packed {
    logic       valid;
    logic [1:0] tap;
  } rd_tag_t;

  // zero behaves as 1, anything above 128 as 128
  function automatic logic [SIDE_W-1:0] side_used(input logic [SIDE_W-1:0] raw);
    logic [SIDE_W-1:0] s;
    begin
      if (raw == '0) begin
        s = 8'd1;
      end else if (raw > MAX_SIDE) begin
        s = MAX_SIDE;
      end else begin
        s = raw;
      end
      return s;
    end
  endfunction

endpackage

[rtl/core/bts_ram.sv]
module bts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/core/bts_addr_gen.sv]
module bts_addr_gen import bts_pkg::*; #(
  parameter int MAX_TEXELS    = MAX_TEXELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF,
  localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  bts_in_t                  in_data,
  output logic                     busy,
  input  logic [SIDE_W-1:0]        tex_w,
  input  logic [SIDE_W-1:0]        tex_h,
  output logic                     ram_we,
  output logic [AW-1:0]            ram_addr,
  output logic [TEXEL_W-1:0]       ram_wdata,
  output rd_tag_t                  iss_tag,
  output logic [FRACTION_BITS-1:0] iss_wx,
  output logic [FRACTION_BITS-1:0] iss_wy
);

  localparam int FB   = FRACTION_BITS;
  localparam int PW   = FB + SIDE_W;
  localparam int CMPW = ((AW > IDX_W) ? AW : IDX_W) + 1;

  // stage 1: scaled positions
  logic               s1_v_r, s1_v_nxt;
  logic               s1_op_r;
  logic [IDX_W-1:0]   s1_addr_r;
  logic [TEXEL_W-1:0] s1_texel_r;
  logic [PW-1:0]      s1_pu_r, s1_pv_r;

  // stage 2: neighbours, row bases, weights
  logic               s2_v_r, s2_v_nxt;
  logic               s2_op_r;
  logic [IDX_W-1:0]   s2_addr_r;
  logic [TEXEL_W-1:0] s2_texel_r;
  logic [POS_W-1:0]   s2_x0_r, s2_x1_r;
  logic [IDX_W-1:0]   s2_row0_r, s2_row1_r;
  logic [FB-1:0]      s2_wx_r, s2_wy_r;

  // sequencer: memory port owner
  logic               sq_v_r, sq_v_nxt;
  logic [1:0]         sq_cnt_r, sq_cnt_nxt;
  logic               sq_op_r;
  logic [IDX_W-1:0]   sq_addr_r;
  logic [TEXEL_W-1:0] sq_texel_r;
  logic [POS_W-1:0]   sq_x0_r, sq_x1_r;
  logic [IDX_W-1:0]   sq_row0_r, sq_row1_r;
  logic [FB-1:0]      sq_wx_r, sq_wy_r;

  logic sq_done, sq_free, s2_go, s2_free, s1_go, s1_free, accept;

  logic [PW-1:0]       pu, pv;
  logic [POS_W-1:0]    x0, y0, x1, y1;
  logic [2*SIDE_W-1:0] row0_full, row1_full;
  logic [IDX_W-1:0]    row_sel, tex_idx;
  logic [POS_W-1:0]    col_sel;
  logic [AW-1:0]       rd_addr;
  logic                wr_in_range;

  // handshake chain
  always_comb begin
    sq_done = sq_v_r & ((sq_op_r == OP_WRITE) | (sq_cnt_r == TAP_BR));
    sq_free = ~sq_v_r | sq_done;
    s2_go   = s2_v_r & sq_free;
    s2_free = ~s2_v_r | sq_free;
    s1_go   = s1_v_r & s2_free;
    s1_free = ~s1_v_r | s2_free;
    accept  = start & s1_free;
    busy    = ~s1_free;

    s1_v_nxt   = accept ? 1'b1 : (s1_go ? 1'b0 : s1_v_r);
    s2_v_nxt   = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_v_r);
    sq_v_nxt   = s2_go ? 1'b1 : (sq_done ? 1'b0 : sq_v_r);
    sq_cnt_nxt = s2_go ? TAP_TL : ((sq_v_r & ~sq_done) ? sq_cnt_r + 2'd1 : sq_cnt_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      sq_v_r   <= 1'b0;
      sq_cnt_r <= TAP_TL;
    end else begin
      s1_v_r   <= s1_v_nxt;
      s2_v_r   <= s2_v_nxt;
      sq_v_r   <= sq_v_nxt;
      sq_cnt_r <= sq_cnt_nxt;
    end
  end

  // fraction times size
  always_comb begin
    pu = PW'(in_data.coord_u[FB-1:0]) * PW'(tex_w);
    pv = PW'(in_data.coord_v[FB-1:0]) * PW'(tex_h);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= in_data.op;
      s1_addr_r  <= in_data.texel_address;
      s1_texel_r <= {in_data.texel_red, in_data.texel_green, in_data.texel_blue};
      s1_pu_r    <= pu;
      s1_pv_r    <= pv;
    end
  end

  // position < size <= 128, so seven bits hold it
  always_comb begin
    x0 = s1_pu_r[FB +: POS_W];
    y0 = s1_pv_r[FB +: POS_W];
    x1 = ((SIDE_W'(x0) + 8'd1) == tex_w) ? '0 : x0 + 7'd1;
    y1 = ((SIDE_W'(y0) + 8'd1) == tex_h) ? '0 : y0 + 7'd1;
    row0_full = (2*SIDE_W)'(y0) * (2*SIDE_W)'(tex_w);
    row1_full = (2*SIDE_W)'(y1) * (2*SIDE_W)'(tex_w);
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_op_r    <= s1_op_r;
      s2_addr_r  <= s1_addr_r;
      s2_texel_r <= s1_texel_r;
      s2_x0_r    <= x0;
      s2_x1_r    <= x1;
      s2_row0_r  <= row0_full[IDX_W-1:0];
      s2_row1_r  <= row1_full[IDX_W-1:0];
      s2_wx_r    <= s1_pu_r[FB-1:0];
      s2_wy_r    <= s1_pv_r[FB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      sq_op_r    <= s2_op_r;
      sq_addr_r  <= s2_addr_r;
      sq_texel_r <= s2_texel_r;
      sq_x0_r    <= s2_x0_r;
      sq_x1_r    <= s2_x1_r;
      sq_row0_r  <= s2_row0_r;
      sq_row1_r  <= s2_row1_r;
      sq_wx_r    <= s2_wx_r;
      sq_wy_r    <= s2_wy_r;
    end
  end

  // tap order: top-left, top-right, bottom-left, bottom-right
  always_comb begin
    row_sel = sq_cnt_r[1] ? sq_row1_r : sq_row0_r;
    col_sel = sq_cnt_r[0] ? sq_x1_r : sq_x0_r;
    tex_idx = row_sel + IDX_W'(col_sel);
    if (CMPW'(tex_idx) >= CMPW'(MAX_TEXELS)) begin
      rd_addr = AW'(MAX_TEXELS - 1);
    end else begin
      rd_addr = AW'(tex_idx);
    end
    wr_in_range = CMPW'(sq_addr_r) < CMPW'(MAX_TEXELS);

    ram_we    = sq_v_r & (sq_op_r == OP_WRITE) & wr_in_range;
    ram_addr  = (sq_op_r == OP_WRITE) ? AW'(sq_addr_r) : rd_addr;
    ram_wdata = sq_texel_r;

    iss_tag.valid = sq_v_r & (sq_op_r == OP_SAMPLE);
    iss_tag.tap   = sq_cnt_r;
    iss_wx        = sq_wx_r;
    iss_wy        = sq_wy_r;
  end

endmodule

[rtl/core/bts_filter.sv]
module bts_filter import bts_pkg::*; #(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rd_tag_t                  iss_tag,
  input  logic [FRACTION_BITS-1:0] iss_wx,
  input  logic [FRACTION_BITS-1:0] iss_wy,
  input  logic [TEXEL_W-1:0]       rdata,
  output logic                     out_valid,
  output bts_out_t                 out_data
);

  localparam int FB = FRACTION_BITS;
  localparam int HW = FB + CH_W + 1;      // horizontal blend arithmetic
  localparam int VW = 2 * FB + CH_W + 1;  // vertical blend arithmetic
  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  rd_tag_t            tag_r;
  logic [FB-1:0]      twx_r, twy_r;
  logic [FB-1:0]      wx_r, wy_r, vwy_r;
  logic [TEXEL_W-1:0] t0_r, t2_r;
  logic [FB+CH_W-1:0] top_r [NUM_CH];
  logic [FB+CH_W-1:0] bot_r [NUM_CH];
  logic               vv_r;
  logic               out_v_r;
  logic [TEXEL_W-1:0] out_r;

  logic [FB:0]        omwx, omwy;
  logic [TEXEL_W-1:0] a_tex;
  logic [HW-1:0]      hsum [NUM_CH];
  logic [VW-1:0]      vsum [NUM_CH];
  logic [TEXEL_W-1:0] vres;

  // tag and weights line up with the registered memory read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r.valid <= 1'b0;
      tag_r.tap   <= TAP_TL;
    end else begin
      tag_r <= iss_tag;
    end
  end

  always_ff @(posedge clk) begin
    twx_r <= iss_wx;
    twy_r <= iss_wy;
  end

  // left texel comes from the held tap, right from the memory
  always_comb begin
    omwx  = ONE - {1'b0, wx_r};
    omwy  = ONE - {1'b0, vwy_r};
    a_tex = (tag_r.tap == TAP_BR) ? t2_r : t0_r;
    for (int k = 0; k < NUM_CH; k++) begin
      hsum[k] = HW'(a_tex[TEXEL_W-1-CH_W*k -: CH_W]) * HW'(omwx)
              + HW'(rdata[TEXEL_W-1-CH_W*k -: CH_W]) * HW'(wx_r);
      vsum[k] = VW'(top_r[k]) * VW'(omwy) + VW'(bot_r[k]) * VW'(vwy_r);
      vres[TEXEL_W-1-CH_W*k -: CH_W] = vsum[k][2*FB +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (tag_r.valid) begin
      unique case (tag_r.tap)
        TAP_TL: begin
          t0_r <= rdata;
          wx_r <= twx_r;
          wy_r <= twy_r;
        end
        TAP_TR: begin
          for (int k = 0; k < NUM_CH; k++) begin
            top_r[k] <= hsum[k][FB+CH_W-1:0];
          end
        end
        TAP_BL: begin
          t2_r <= rdata;
        end
        TAP_BR: begin
          for (int k = 0; k < NUM_CH; k++) begin
            bot_r[k] <= hsum[k][FB+CH_W-1:0];
          end
          vwy_r <= wy_r;
        end
        default: begin
          t2_r <= t2_r;
        end
      endcase
    end
    if (vv_r) begin
      out_r <= vres;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vv_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      vv_r    <= tag_r.valid & (tag_r.tap == TAP_BR);
      out_v_r <= vv_r;
    end
  end

  always_comb begin
    out_valid          = out_v_r;
    out_data.out_red   = out_r[TEXEL_W-1 -: CH_W];
    out_data.out_green = out_r[TEXEL_W-1-CH_W -: CH_W];
    out_data.out_blue  = out_r[CH_W-1:0];
  end

endmodule

[rtl/core/bilinear_texture_sampler_unit.sv]
// Channel   | Handshake                         | Payload
// ----------+-----------------------------------+-------------------------------
// request   | start in, busy out; taken when    | in_data  (bts_in_t)
//           | start & !busy                     |
// result    | out_valid strobe, one cycle,      | out_data (bts_out_t)
//           | no back-pressure                  |
// config    | APB write on psel&penable&pwrite  | paddr[2] picks width/height
//
// A sample request holds the single texture memory port for four texel reads
// (one per cycle), a write request for a single write; that port sets the
// sample rate. Requests flow in order through two address stages and the
// port sequencer, so busy only rises when all three are full.
// rst_n is synchronous, active low, and clears control state and the size
// registers (128); the texture memory itself is not cleared.
// The result side cannot stall, so nothing inside ever waits on it.
module bilinear_texture_sampler_unit import bts_pkg::*; #(
  parameter int MAX_TEXELS    = MAX_TEXELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  bts_in_t           in_data,
  // result channel
  output logic              out_valid,
  output bts_out_t          out_data,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;

  logic [SIDE_W-1:0] tex_width_r, tex_height_r;
  logic [SIDE_W-1:0] w_used, h_used;
  logic              cfg_wr;

  logic                     ram_we;
  logic [AW-1:0]            ram_addr;
  logic [TEXEL_W-1:0]       ram_wdata, ram_rdata;
  rd_tag_t                  iss_tag;
  logic [FRACTION_BITS-1:0] iss_wx, iss_wy;

  // size registers; only paddr[2] is decoded
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= MAX_SIDE;
      tex_height_r <= MAX_SIDE;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TEX_HEIGHT) begin
        tex_height_r <= pwdata[SIDE_W-1:0];
      end else begin
        tex_width_r <= pwdata[SIDE_W-1:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TEX_WIDTH) ? CFG_DW'(tex_width_r) : CFG_DW'(tex_height_r);

  // out-of-range sizes clamp to 1..128
  assign w_used = side_used(tex_width_r);
  assign h_used = side_used(tex_height_r);

  bts_addr_gen #(
    .MAX_TEXELS    (MAX_TEXELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_addr (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_data   (in_data),
    .busy      (busy),
    .tex_w     (w_used),
    .tex_h     (h_used),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .iss_tag   (iss_tag),
    .iss_wx    (iss_wx),
    .iss_wy    (iss_wy)
  );

  bts_ram #(
    .WIDTH (TEXEL_W),
    .DEPTH (MAX_TEXELS)
  ) u_tex_mem (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  bts_filter #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_filter (
    .clk       (clk),
    .rst_n     (rst_n),
    .iss_tag   (iss_tag),
    .iss_wx    (iss_wx),
    .iss_wy    (iss_wy),
    .rdata     (ram_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import bts_pkg::*;

  localparam int FB = FRACTION_BITS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_PER_SIZE = 290;  // six size settings, ~1750 requests in all

  // texel addresses and blend weights of one sample, taps in TAP_* order
  typedef struct packed {
    logic [3:0][IDX_W-1:0] tap;
    logic [FB-1:0]         wx;
    logic [FB-1:0]         wy;
  } footprint_t;

  // a queued request together with the sender's idle chance while it waits
  typedef struct {
    bts_in_t     req;
    int unsigned idle_pct;
  } pending_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  bts_in_t           in_data = '0;
  logic              out_valid;
  bts_out_t          out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // Mirror of the block: size registers as written, texel store as accepted
  logic [SIDE_W-1:0]  width_raw = MAX_SIDE;
  logic [SIDE_W-1:0]  height_raw = MAX_SIDE;
  logic [TEXEL_W-1:0] texture_mirror [MAX_TEXELS_DEF];
  // Generation-time view: which texels a queued write has already covered,
  // so a sample never reaches a texel that was never written
  bit                 texel_written [MAX_TEXELS_DEF];

  pending_t    pending[$];
  bts_out_t    expected_pixels[$];
  int unsigned requests_queued = 0;
  int unsigned requests_taken = 0;
  int unsigned writes_taken = 0;
  int unsigned pixels_checked = 0;
  int unsigned size_settings = 0;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  bilinear_texture_sampler_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Filtering model
  // ---------------------------------------------------------------------

  // zero acts as one texel, anything past 128 as 128
  function automatic int unsigned clamp_side(input logic [SIDE_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_SIDE) return int'(MAX_SIDE);
    return int'(raw);
  endfunction

  // Integer part of u/v is dropped (wrap). The fraction scaled by the side
  // gives the texel column/row and the weight; right/lower neighbour wraps.
  function automatic footprint_t texel_footprint(input logic [31:0] u,
                                                 input logic [31:0] v);
    footprint_t  fp;
    int unsigned w, h, pu, pv, x0, x1, y0, y1;
    w  = clamp_side(width_raw);
    h  = clamp_side(height_raw);
    pu = 32'(u[FB-1:0]) * w;
    pv = 32'(v[FB-1:0]) * h;
    x0 = pu >> FB;
    y0 = pv >> FB;
    x1 = (x0 + 1 == w) ? 0 : x0 + 1;
    y1 = (y0 + 1 == h) ? 0 : y0 + 1;
    fp.wx = pu[FB-1:0];
    fp.wy = pv[FB-1:0];
    fp.tap[TAP_TL] = IDX_W'(y0 * w + x0);
    fp.tap[TAP_TR] = IDX_W'(y0 * w + x1);
    fp.tap[TAP_BL] = IDX_W'(y1 * w + x0);
    fp.tap[TAP_BR] = IDX_W'(y1 * w + x1);
    return fp;
  endfunction

  // Horizontal blends keep all fraction bits; the vertical blend's 2*FB
  // fraction bits are truncated away.
  function automatic bts_out_t blend_pixel(input bts_in_t req);
    footprint_t                   fp;
    logic [3:0][TEXEL_W-1:0]      tex;
    logic [63:0]                  one, top, bot, acc;
    logic [NUM_CH-1:0][CH_W-1:0]  pix;
    int                           t, ch;
    fp  = texel_footprint(req.coord_u, req.coord_v);
    one = 64'd1 << FB;
    for (t = 0; t < 4; t++) tex[t] = texture_mirror[fp.tap[t]];
    for (ch = 0; ch < NUM_CH; ch++) begin
      top = 64'(tex[TAP_TL][ch*CH_W +: CH_W]) * (one - 64'(fp.wx)) +
            64'(tex[TAP_TR][ch*CH_W +: CH_W]) * 64'(fp.wx);
      bot = 64'(tex[TAP_BL][ch*CH_W +: CH_W]) * (one - 64'(fp.wx)) +
            64'(tex[TAP_BR][ch*CH_W +: CH_W]) * 64'(fp.wx);
      acc = top * (one - 64'(fp.wy)) + bot * 64'(fp.wy);
      pix[ch] = acc[2*FB +: CH_W];
    end
    return bts_out_t'(pix);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  // ---------------------------------------------------------------------
  // Request generation
  // ---------------------------------------------------------------------

  // unused fields of a request carry random bits
  function automatic bts_in_t random_request();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(bts_in_t)-1:0];
  endfunction

  // sender idles 31% for the first third, 88% for the second, never after
  task automatic push_request(input bts_in_t r);
    int unsigned pct;
    pct = (requests_queued < 585) ? 31 : (requests_queued < 1170) ? 88 : 0;
    pending.push_back('{req: r, idle_pct: pct});
    requests_queued++;
  endtask

  task automatic queue_write(input logic [IDX_W-1:0] addr, input logic [TEXEL_W-1:0] rgb);
    bts_in_t r;
    r = random_request();
    r.op = OP_WRITE;
    r.texel_address = addr;
    {r.texel_red, r.texel_green, r.texel_blue} = rgb;
    texel_written[addr] = 1'b1;
    push_request(r);
  endtask

  // fills any tap not yet written with a random texel, then the sample itself
  task automatic queue_sample(input logic [31:0] u, input logic [31:0] v);
    footprint_t fp;
    bts_in_t    r;
    int         t;
    fp = texel_footprint(u, v);
    for (t = 0; t < 4; t++)
      if (!texel_written[fp.tap[t]]) queue_write(fp.tap[t], TEXEL_W'($urandom));
    r = random_request();
    r.op = OP_SAMPLE;
    r.coord_u = u;
    r.coord_v = v;
    push_request(r);
  endtask

  // mostly random, with fractions pinned to 0, all ones, or texel edges
  function automatic logic [31:0] pick_coord(input int unsigned side);
    logic [31:0] c;
    int unsigned k;
    c = $urandom;
    k = $urandom_range(side - 1);
    case ($urandom_range(9))
      0: c[FB-1:0] = '0;
      1: c[FB-1:0] = '1;
      2: c[FB-1:0] = FB'(((1 << FB) * k) / side);
      3: c[FB-1:0] = FB'(((1 << FB) * (k + 1)) / side - 1);
      default: ;
    endcase
    return c;
  endfunction

  // queues random requests, fill writes included, until count more are pending
  task automatic queue_random(input int unsigned count);
    int unsigned target;
    target = requests_queued + count;
    while (requests_queued < target) begin
      if ($urandom_range(99) < 25) begin
        queue_write(IDX_W'($urandom), TEXEL_W'($urandom));
      end else begin
        queue_sample(pick_coord(clamp_side(width_raw)), pick_coord(clamp_side(height_raw)));
      end
    end
  endtask

  // wait for every request taken, every pixel back and the pipe empty
  task automatic drain();
    while (requests_taken != requests_queued || expected_pixels.size() != 0 || busy)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write (setup + access), then read back through the same port
  task automatic program_size(input logic reg_sel, input logic [SIDE_W-1:0] value);
    logic [CFG_DW-1:0] word;
    word = $urandom;
    word[SIDE_W-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_TEX_WIDTH) width_raw = value;
    else height_raw = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== 32'(value))
      report_mismatch(reg_sel == REG_TEX_WIDTH ? "tex_width readback" : "tex_height readback",
                      32'(value), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // registers change only with the block idle
  task automatic set_sizes(input logic [SIDE_W-1:0] w, input logic [SIDE_W-1:0] h);
    drain();
    program_size(REG_TEX_WIDTH, w);
    program_size(REG_TEX_HEIGHT, h);
    size_settings++;
  endtask

  // ---------------------------------------------------------------------
  // Request driver: presents the next pending request, holds it while busy
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        // request taken at this edge: update the mirror or predict the pixel
        requests_taken++;
        if (in_data.op == OP_SAMPLE) begin
          expected_pixels.push_back(blend_pixel(in_data));
        end else begin
          texture_mirror[in_data.texel_address] =
            {in_data.texel_red, in_data.texel_green, in_data.texel_blue};
          writes_taken++;
        end
      end
      if (!start || !busy) begin
        if (pending.size() != 0 && $urandom_range(99) >= pending[0].idle_pct) begin
          in_data <= pending[0].req;
          start   <= 1'b1;
          pending.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result monitor: each strobe against the oldest predicted pixel
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    bts_out_t want;
    if (rst_n && out_valid) begin
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: result mismatch, expected none, actual %0h", $time, out_data);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_data.out_red !== want.out_red)
          report_mismatch("out_red", 32'(want.out_red), 32'(out_data.out_red));
        if (out_data.out_green !== want.out_green)
          report_mismatch("out_green", 32'(want.out_green), 32'(out_data.out_green));
        if (out_data.out_blue !== want.out_blue)
          report_mismatch("out_blue", 32'(want.out_blue), 32'(out_data.out_blue));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Sequence: reset, then one block of requests per texture size
  // ---------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // full 128x128 texture; directed corners and wrap cases first
    set_sizes(8'd128, 8'd128);
    queue_write(14'd0, 24'hFFFFFF);
    queue_write(14'd16383, 24'h000000);
    queue_write(14'd127, 24'h00FF00);
    queue_write(14'd128, 24'hFF0000);
    queue_write(14'd129, 24'h0000FF);
    queue_write(14'd16256, 24'hFFFFFF);
    queue_write(14'h1555, 24'hAA55AA);
    queue_write(14'h2AAA, 24'h55AA55);
    queue_sample(32'h0000_0000, 32'h0000_0000);   // exact texel, zero weights
    queue_sample(32'h0000_FFFF, 32'h0000_FFFF);   // last texel, both neighbours wrap
    queue_sample(32'h8000_0000, 32'h7FFF_FFFF);   // most negative / most positive
    queue_sample(32'hFFFF_FFFF, 32'hFFFF_0000);   // negative, wraps as 1.0 - eps
    queue_sample(32'h0000_8000, 32'h0000_8000);   // half-way blend
    queue_sample(32'hFFFF_8000, 32'h0001_0000);   // -0.5, and whole 1.0 -> 0
    queue_sample(32'h1234_0001, 32'hFEDC_7FFF);
    queue_sample(32'h7FFF_0100, 32'h8000_FF00);
    queue_random(RANDOM_PER_SIZE);

    set_sizes(8'd1, 8'd1);            // every tap is texel 0
    queue_random(RANDOM_PER_SIZE);
    set_sizes(8'd0, 8'd200);          // out of range: 1 wide, 128 high
    queue_random(RANDOM_PER_SIZE);
    set_sizes(8'd7, 8'd3);
    queue_random(RANDOM_PER_SIZE);
    set_sizes(8'd255, 8'd0);          // out of range: 128 wide, 1 high
    queue_random(RANDOM_PER_SIZE);
    set_sizes(8'($urandom_range(128, 1)), 8'($urandom_range(128, 1)));
    queue_random(RANDOM_PER_SIZE);

    drain();
    $display("Covered %0d requests (%0d texel writes), %0d filtered pixels compared",
             requests_taken, writes_taken, pixels_checked);
    $display("across %0d texture sizes, incl. 1x1, 128x128 and out-of-range settings",
             size_settings);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/bts_pkg.sv
rtl/core/bts_ram.sv
rtl/core/bts_addr_gen.sv
rtl/core/bts_filter.sv
rtl/core/bilinear_texture_sampler_unit.sv
tb/testbench.sv
